// ===== rtl/cfr_pkg.sv =====
package cfr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned KindW  = 3;
    localparam int unsigned CountW = 9;
    localparam int unsigned TailN  = 3;

    localparam logic [ByteW-1:0]  BYTE_START     = 8'h05;
    localparam logic [ByteW-1:0]  BYTE_END       = 8'h04;
    localparam logic [ByteW-1:0]  LOW_BAD_LIMIT  = 8'h21;
    localparam logic [ByteW-1:0]  HIGH_BAD_LIMIT = 8'h7E;
    localparam logic [CountW-1:0] MAX_BODY_RESET = 9'd260;
    localparam logic [CountW-1:0] MIN_BODY       = 9'd3;

    typedef enum logic [KindW-1:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_OK       = 3'd1,
        KIND_MISMATCH = 3'd2,
        KIND_BADCHAR  = 3'd3,
        KIND_TOOLONG  = 3'd4,
        KIND_TOOSHORT = 3'd5
    } t_kind;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [ByteW-1:0] value;
    } t_result;

    // Uppercase hex digit to its value; anything else counts as zero.
    function automatic logic [3:0] hex_digit(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'd48;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'd55;
        end
        return d[3:0];
    endfunction

endpackage

// ===== rtl/cfr_if.sv =====
interface cfr_byte_if;
    import cfr_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_event_if;
    import cfr_pkg::*;
    logic             valid;
    logic             ready;
    logic [KindW-1:0] event_kind;
    logic [ByteW-1:0] event_value;

    modport source (output valid, output event_kind, output event_value, input ready);
    modport sink (input valid, input event_kind, input event_value, output ready);
endinterface

// ===== rtl/cfr_in_stage.sv =====
module cfr_in_stage
    import cfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    cfr_byte_if.sink         i_rx,
    input  logic             i_advance,
    output logic             o_valid,
    output logic [ByteW-1:0] o_byte
);

    logic             r_valid;
    logic [ByteW-1:0] r_byte;
    logic             n_valid;

    assign i_rx.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_rx.ready) begin
            n_valid = i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload: load on every transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/cfr_deframer.sv =====
module cfr_deframer
    import cfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CountW-1:0] i_cfg_wr_data,
    input  logic              i_step,
    input  logic [ByteW-1:0]  i_byte,
    output t_result           o_result
);

    logic              r_listening;
    logic [CountW-1:0] r_count;
    logic [ByteW-1:0]  r_sum;
    logic [CountW-1:0] r_max_len;
    logic [ByteW-1:0]  r_tail [TailN];

    logic              n_listening;
    logic [CountW-1:0] n_count;
    logic [ByteW-1:0]  n_sum;
    logic              shift_en;
    logic [ByteW-1:0]  given;
    t_result           result;

    assign given = {hex_digit(r_tail[1]), hex_digit(r_tail[2])};

    always_comb begin
        n_listening  = r_listening;
        n_count      = r_count;
        n_sum        = r_sum;
        shift_en     = 1'b0;
        result.valid = 1'b0;
        result.kind  = KIND_PAYLOAD;
        result.value = '0;
        priority if (i_byte == BYTE_START) begin
            n_listening = 1'b1;
            n_count     = '0;
            n_sum       = '0;
        end else if (!r_listening) begin
            // drop bytes outside a frame
        end else if (i_byte == BYTE_END) begin
            n_listening  = 1'b0;
            result.valid = 1'b1;
            if (r_count < MIN_BODY) begin
                result.kind = KIND_TOOSHORT;
            end else if (given == r_sum) begin
                result.kind = KIND_OK;
            end else begin
                result.kind  = KIND_MISMATCH;
                result.value = r_sum;
            end
        end else if (i_byte <= LOW_BAD_LIMIT || i_byte >= HIGH_BAD_LIMIT) begin
            n_listening  = 1'b0;
            result.valid = 1'b1;
            result.kind  = KIND_BADCHAR;
        end else if (r_count >= r_max_len) begin
            n_listening  = 1'b0;
            result.valid = 1'b1;
            result.kind  = KIND_TOOLONG;
        end else begin
            shift_en = 1'b1;
            n_count  = r_count + 1'b1;
            // byte leaving the delay line is covered by the checksum
            if (r_count >= MIN_BODY) begin
                n_sum        = r_sum + r_tail[0];
                result.valid = 1'b1;
                result.value = r_tail[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listening <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_max_len   <= MAX_BODY_RESET;
        end else begin
            if (i_step) begin
                r_listening <= n_listening;
                r_count     <= n_count;
                r_sum       <= n_sum;
            end
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && shift_en) begin
            r_tail[0] <= r_tail[1];
            r_tail[1] <= r_tail[2];
            r_tail[2] <= i_byte;
        end
    end

    assign o_result = result;

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_byte == BYTE_START |=> r_listening && r_count == '0 && r_sum == '0)
        else $error("start byte did not open a clean frame");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !r_listening && i_byte != BYTE_START |=> !r_listening && $stable(r_count))
        else $error("byte outside a frame changed state");

    a_payload_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.valid && o_result.kind == KIND_PAYLOAD |-> r_count >= MIN_BODY)
        else $error("payload emitted before delay line filled");

    a_close_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_listening && !n_listening && i_byte != BYTE_START |-> o_result.valid)
        else $error("frame closed without an event");

endmodule

// ===== rtl/cfr_out_stage.sv =====
module cfr_out_stage
    import cfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_room,
    cfr_event_if.source o_evt
);

    logic             r_valid;
    t_kind            r_kind;
    logic [ByteW-1:0] r_value;
    logic             n_valid;

    assign o_room = !r_valid || o_evt.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_result.valid;
        end else if (o_evt.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_kind  <= i_result.kind;
            r_value <= i_result.value;
        end
    end

    assign o_evt.valid       = r_valid;
    assign o_evt.event_kind  = r_kind;
    assign o_evt.event_value = r_value;

endmodule

// ===== rtl/checksummed_frame_receiver.sv =====
// Channel  Direction  Transfer when        Payload
// i_rx     in         valid && ready       rx_byte[7:0]
// o_evt    out        valid && ready       event_kind[2:0], event_value[7:0]
// cfg      in         i_cfg_wr_en          i_cfg_wr_data[8:0] (max_body_length)
//
// One byte per cycle sustained while the result register is not stalled; each byte passes
// the input register, then goes through the deframer into the result register.
// Bytes that cause no event pass through without using the result register.
// Synchronous active-low reset closes any frame and restores the length limit to 260.
// A stalled result register holds the input register; i_rx.ready drops only then.
module checksummed_frame_receiver
    import cfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfr_byte_if.sink          i_rx,
    cfr_event_if.source       o_evt,
    input  logic              i_cfg_wr_en,
    input  logic [CountW-1:0] i_cfg_wr_data
);

    logic             s1_valid;
    logic [ByteW-1:0] s1_byte;
    logic             room;
    logic             advance;
    t_result          result;

    assign advance = s1_valid && room;

    cfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_byte    (s1_byte)
    );

    cfr_deframer u_dfr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_byte        (s1_byte),
        .o_result      (result)
    );

    cfr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_room   (room),
        .o_evt    (o_evt)
    );

endmodule

// ===== dv/checksummed_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module checksummed_frame_receiver_test;
    import cfr_pkg::*;

    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [ByteW-1:0] DIRECTED_BYTES [25] = '{
        8'h04, 8'h41,                             // ignored outside a frame
        8'h05, 8'h04,                             // empty body
        8'h05, 8'h22, 8'h3B, 8'h32, 8'h32, 8'h04, // good frame, sum 0x22
        8'h05, 8'h7D, 8'h21,                      // bad character, low side
        8'h05, 8'h41, 8'h05,                      // restart drops the open frame
        8'h41, 8'h3B, 8'h30, 8'h30, 8'h04,        // checksum mismatch
        8'h05, 8'hFF,                             // bad character, high side
        8'h05, 8'h7E
    };

    typedef struct {
        t_kind            kind;
        logic [ByteW-1:0] value;
    } t_frame_event;

    class t_deframer_scoreboard;
        logic [CountW-1:0] length_limit;
        bit                in_frame;
        logic [9:0]        body_len;
        logic [ByteW-1:0]  body_sum;
        logic [ByteW-1:0]  tail [TailN];
        t_frame_event      expected_events [$];
        int                errors;

        function new();
            length_limit = MAX_BODY_RESET;
            in_frame     = 1'b0;
            body_len     = '0;
            body_sum     = '0;
            foreach (tail[i]) tail[i] = '0;
            errors       = 0;
        endfunction

        function logic [3:0] digit_of(logic [ByteW-1:0] c);
            if (c >= 8'h30 && c <= 8'h39) begin
                return c[3:0];
            end
            if (c >= 8'h41 && c <= 8'h46) begin
                return c[3:0] + 4'd9;
            end
            return 4'd0;
        endfunction

        function void push_event(t_kind k, logic [ByteW-1:0] v);
            t_frame_event e;
            e.kind  = k;
            e.value = v;
            expected_events.push_back(e);
        endfunction

        // Advance the deframer by one accepted byte.
        function void note_byte(logic [ByteW-1:0] b);
            logic [ByteW-1:0] leaving;
            logic [ByteW-1:0] given;
            bit               full;
            if (b == BYTE_START) begin
                in_frame = 1'b1;
                body_len = '0;
                body_sum = '0;
                return;
            end
            if (!in_frame) begin
                return;
            end
            if (b == BYTE_END) begin
                in_frame = 1'b0;
                if (body_len < 10'd3) begin
                    push_event(KIND_TOOSHORT, '0);
                end else begin
                    given = {digit_of(tail[1]), digit_of(tail[2])};
                    if (given == body_sum) begin
                        push_event(KIND_OK, '0);
                    end else begin
                        push_event(KIND_MISMATCH, body_sum);
                    end
                end
                return;
            end
            if (b <= LOW_BAD_LIMIT || b >= HIGH_BAD_LIMIT) begin
                in_frame = 1'b0;
                push_event(KIND_BADCHAR, '0);
                return;
            end
            if (body_len >= {1'b0, length_limit}) begin
                in_frame = 1'b0;
                push_event(KIND_TOOLONG, '0);
                return;
            end
            leaving  = tail[0];
            full     = body_len >= 10'd3;
            tail[0]  = tail[1];
            tail[1]  = tail[2];
            tail[2]  = b;
            body_len = body_len + 10'd1;
            if (full) begin
                body_sum = body_sum + leaving;
                push_event(KIND_PAYLOAD, leaving);
            end
        endfunction

        function void check_event(logic [KindW-1:0] k, logic [ByteW-1:0] v);
            t_frame_event e;
            if (expected_events.size() == 0) begin
                $error("unexpected event: event_kind %0d event_value 0x%02h", k, v);
                errors++;
                return;
            end
            e = expected_events.pop_front();
            if (k !== e.kind) begin
                $error("event_kind: expected %0d, got %0d", e.kind, k);
                errors++;
            end
            if (v !== e.value) begin
                $error("event_value: expected 0x%02h, got 0x%02h", e.value, v);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [CountW-1:0] cfg_wr_data;

    cfr_byte_if  rx_if ();
    cfr_event_if evt_if ();

    t_deframer_scoreboard board;
    bit                   rx_steady;
    bit                   evt_steady;
    bit                   long_hold_request;
    int                   frame_bytes_sent;

    checksummed_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (rx_if),
        .o_evt         (evt_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ByteW-1:0] printable_byte();
        return ByteW'($urandom_range(LOW_BAD_LIMIT + 1, HIGH_BAD_LIMIT - 1));
    endfunction

    function automatic logic [ByteW-1:0] bad_byte();
        logic [ByteW-1:0] c;
        do begin
            c = ByteW'($urandom_range(0, 255));
        end while ((c > LOW_BAD_LIMIT && c < HIGH_BAD_LIMIT) ||
                   c == BYTE_START || c == BYTE_END);
        return c;
    endfunction

    function automatic logic [ByteW-1:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    task automatic send_byte(logic [ByteW-1:0] b);
        int gap;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (rx_if.ready !== 1'b1) @(posedge i_clk);
        board.note_byte(b);
        gap = pick_gap(rx_steady);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(int payload_len, bit corrupt);
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        sum = '0;
        send_byte(BYTE_START);
        repeat (payload_len) begin
            b   = printable_byte();
            sum = sum + b;
            send_byte(b);
        end
        send_byte(printable_byte());
        if (corrupt) begin
            send_byte(printable_byte());
            send_byte(printable_byte());
        end else begin
            send_byte(hex_char(sum[7:4]));
            send_byte(hex_char(sum[3:0]));
        end
        send_byte(BYTE_END);
        frame_bytes_sent += payload_len + 5;
    endtask

    // Open a frame and cut it short with a bad byte, a restart or an early end.
    task automatic send_broken_frame();
        int n;
        n = $urandom_range(0, 6);
        send_byte(BYTE_START);
        repeat (n) send_byte(printable_byte());
        case ($urandom_range(0, 2))
            0: begin
                send_byte(bad_byte());
            end
            1: begin
                send_byte(BYTE_START);
            end
            default: begin
                send_byte(BYTE_END);
            end
        endcase
        frame_bytes_sent += n + 2;
    endtask

    task automatic run_phase(int budget);
        int pick;
        int lim;
        int n;
        frame_bytes_sent = 0;
        lim = int'(board.length_limit);
        while (frame_bytes_sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame($urandom_range(0, 12), $urandom_range(0, 4) == 0);
            end else if (pick < 70) begin
                send_broken_frame();
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom_range(0, 255)));
            end else if (pick < 90 && (lim <= 40 || $urandom_range(0, 15) == 0)) begin
                // land just below, on and just over the length limit
                n = lim - 4 + $urandom_range(0, 2);
                send_frame((n < 0) ? 0 : n, 1'b0);
            end else begin
                send_frame($urandom_range(13, 40), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic set_length_limit(logic [CountW-1:0] v);
        rx_if.valid <= 1'b0;
        while (board.expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        board.length_limit = v;
    endtask

    initial begin : event_sink
        int hold_left;
        hold_left = 0;
        evt_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
                board.check_event(evt_if.event_kind, evt_if.event_value);
            end
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                hold_left         = LONG_HOLD;
            end
            if (hold_left > 0) begin
                evt_if.ready <= 1'b0;
                hold_left--;
            end else begin
                evt_if.ready <= 1'b1;
                hold_left = pick_gap(evt_steady);
            end
            @(posedge i_clk);
        end
    end

    initial begin
        board             = new();
        rx_steady         = 1'b0;
        evt_steady        = 1'b0;
        long_hold_request = 1'b0;
        i_rst_n       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

        // hold the event side off while payload keeps arriving
        long_hold_request = 1'b1;
        run_phase(400);

        set_length_limit(MIN_BODY);
        run_phase(300);

        set_length_limit(9'd511);
        rx_steady  = 1'b1;
        evt_steady = 1'b1;
        run_phase(400);
        rx_steady  = 1'b0;
        evt_steady = 1'b0;

        set_length_limit(CountW'($urandom_range(MIN_BODY, 511)));
        long_hold_request = 1'b1;
        run_phase(300);

        set_length_limit(CountW'($urandom_range(4, 24)));
        evt_steady = 1'b1;
        run_phase(300);
        evt_steady = 1'b0;

        set_length_limit(MAX_BODY_RESET);
        run_phase(300);

        rx_if.valid <= 1'b0;
        while (board.expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.expected_events.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
